// ===== design/lge_pkg.sv =====
// shared types and constants for the life grid generation engine
package lge_pkg;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 6;

   localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   typedef struct packed {
      logic load_req;
      logic rd_cell;
      logic cell_update;
      logic sweep_start;
      logic sweep_prime;
      logic sweep_run;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             coord_ok;
      logic             sweep_last;
      logic             rsp_free;
   } ctl_status_type;

endpackage

// ===== design/lge_intf.sv =====
// request and response channel interfaces
interface lge_req_intf;
   logic                        valid;
   logic                        ready;
   logic [lge_pkg::CMD_W-1:0]   cmd;
   logic [lge_pkg::COORD_W-1:0] col;
   logic [lge_pkg::COORD_W-1:0] row;

   modport source (output valid, output cmd, output col, output row, input ready);
   modport sink (input valid, input cmd, input col, input row, output ready);
endinterface

interface lge_rsp_intf;
   logic valid;
   logic ready;
   logic cell_alive;
   logic coord_ok;

   modport source (output valid, output cell_alive, output coord_ok, input ready);
   modport sink (input valid, input cell_alive, input coord_ok, output ready);
endinterface

// ===== design/lge_dpath.sv =====
// grid row memory, next generation logic and response register
module lge_dpath #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lge_pkg::ctl_cmd_type          ctl_i,
   output lge_pkg::ctl_status_type       status_o,
   input  logic [lge_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lge_pkg::COORD_W-1:0]   req_col,
   input  logic [lge_pkg::COORD_W-1:0]   req_row,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_cell_alive,
   output logic                          rsp_coord_ok
);

   localparam int AW  = $clog2(GRID_ROWS);
   localparam int CLW = $clog2(GRID_COLS);
   localparam int RW  = $clog2(GRID_ROWS + 2);
   localparam int XW  = lge_pkg::COORD_W + 1;
   localparam logic [3:0] N_SURVIVE = 4'd2;
   localparam logic [3:0] N_BIRTH   = 4'd3;

   function automatic logic [GRID_COLS-1:0] life_row(input logic [GRID_COLS-1:0] a,
                                                     input logic [GRID_COLS-1:0] h,
                                                     input logic [GRID_COLS-1:0] b);
      logic [GRID_COLS+1:0] ap;
      logic [GRID_COLS+1:0] hp;
      logic [GRID_COLS+1:0] bp;
      logic [3:0]           n;
      logic [GRID_COLS-1:0] r;
      ap = {1'b0, a, 1'b0};
      hp = {1'b0, h, 1'b0};
      bp = {1'b0, b, 1'b0};
      r  = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2]) + 4'(hp[c]) + 4'(hp[c+2])
           + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
         r[c] = (n == N_BIRTH) || (h[c] && (n == N_SURVIVE));
      end
      return r;
   endfunction

   logic [lge_pkg::CMD_W-1:0]   cmd_ff;
   logic [lge_pkg::COORD_W-1:0] col_ff;
   logic [lge_pkg::COORD_W-1:0] row_ff;
   logic                        res_alive_ff;
   logic                        res_alive_in;
   logic                        res_ok_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_alive_ff;
   logic                        rsp_ok_ff;

   logic [GRID_COLS-1:0] mem [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_valid_ff;
   logic [GRID_COLS-1:0] rd_data_ff;
   logic                 rd_live_ff;
   logic [GRID_COLS-1:0] above_ff;
   logic [GRID_COLS-1:0] here_ff;
   logic [RW-1:0]        rd_row_ff;
   logic [AW-1:0]        wr_row_ff;

   logic                 rd_en;
   logic                 rd_blank;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [GRID_COLS-1:0] wr_data;
   logic [GRID_COLS-1:0] row_word;
   logic [GRID_COLS-1:0] next_word;
   logic [GRID_COLS-1:0] flip_word;
   logic                 req_in_grid;
   logic                 req_ok;

   assign req_in_grid = ({1'b0, req_col} < XW'(GRID_COLS)) && ({1'b0, req_row} < XW'(GRID_ROWS));
   assign req_ok = (req_cmd == lge_pkg::CMD_STEP)
                || (((req_cmd == lge_pkg::CMD_TOGGLE) || (req_cmd == lge_pkg::CMD_READ))
                    && req_in_grid);

   assign status_o.cmd        = cmd_ff;
   assign status_o.coord_ok   = ({1'b0, col_ff} < XW'(GRID_COLS))
                             && ({1'b0, row_ff} < XW'(GRID_ROWS));
   assign status_o.sweep_last = (wr_row_ff == AW'(GRID_ROWS - 1));
   assign status_o.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign row_word  = rd_live_ff ? rd_data_ff : '0;
   assign next_word = life_row(above_ff, here_ff, row_word);
   assign flip_word = row_word ^ (GRID_COLS'(1) << col_ff[CLW-1:0]);

   // read port select
   always_comb begin
      rd_en    = 1'b0;
      rd_blank = 1'b0;
      rd_addr  = '0;
      if (ctl_i.rd_cell) begin
         rd_en   = 1'b1;
         rd_addr = row_ff[AW-1:0];
      end else if (ctl_i.sweep_start) begin
         rd_en = 1'b1;
      end else if (ctl_i.sweep_prime || ctl_i.sweep_run) begin
         if (rd_row_ff >= RW'(GRID_ROWS)) begin
            rd_blank = 1'b1;
         end else begin
            rd_en   = 1'b1;
            rd_addr = rd_row_ff[AW-1:0];
         end
      end
   end

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (ctl_i.sweep_run) begin
         wr_en   = 1'b1;
         wr_addr = wr_row_ff;
         wr_data = next_word;
      end else if (ctl_i.cell_update && (cmd_ff == lge_pkg::CMD_TOGGLE)) begin
         wr_en   = 1'b1;
         wr_addr = row_ff[AW-1:0];
         wr_data = flip_word;
      end
   end

   always_comb begin
      if (cmd_ff == lge_pkg::CMD_TOGGLE) begin
         res_alive_in = flip_word[col_ff[CLW-1:0]];
      end else begin
         res_alive_in = row_word[col_ff[CLW-1:0]];
      end
   end

   assign rsp_valid_in = ctl_i.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en || rd_blank) begin
         rd_live_ff <= rd_en && row_valid_ff[rd_addr];
      end
      if (ctl_i.load_req) begin
         cmd_ff       <= req_cmd;
         col_ff       <= req_col;
         row_ff       <= req_row;
         res_ok_ff    <= req_ok;
         res_alive_ff <= 1'b0;
      end else if (ctl_i.cell_update) begin
         res_alive_ff <= res_alive_in;
      end
      if (ctl_i.sweep_start) begin
         above_ff  <= '0;
         rd_row_ff <= RW'(1);
      end else if (ctl_i.sweep_prime) begin
         here_ff   <= row_word;
         rd_row_ff <= rd_row_ff + RW'(1);
         wr_row_ff <= '0;
      end else if (ctl_i.sweep_run) begin
         above_ff  <= here_ff;
         here_ff   <= row_word;
         rd_row_ff <= rd_row_ff + RW'(1);
         wr_row_ff <= wr_row_ff + AW'(1);
      end
      if (ctl_i.load_rsp) begin
         rsp_alive_ff <= res_alive_ff;
         rsp_ok_ff    <= res_ok_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_alive = rsp_alive_ff;
   assign rsp_coord_ok   = rsp_ok_ff;

   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      ctl_i.cell_update |-> res_ok_ff)
      else $error("cell update on a request flagged out of grid");

endmodule

// ===== design/lge_ctrl.sv =====
// request sequencing state machine
module lge_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lge_pkg::ctl_status_type status_i,
   output lge_pkg::ctl_cmd_type    ctl_o
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_CELL   = 3'd2;
   localparam logic [2:0] ST_PRIME  = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      ctl_o    = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_o.load_req = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status_i.cmd == lge_pkg::CMD_STEP) begin
               ctl_o.sweep_start = 1'b1;
               state_in          = ST_PRIME;
            end else if (((status_i.cmd == lge_pkg::CMD_TOGGLE)
                          || (status_i.cmd == lge_pkg::CMD_READ)) && status_i.coord_ok) begin
               ctl_o.rd_cell = 1'b1;
               state_in      = ST_CELL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CELL: begin
            ctl_o.cell_update = 1'b1;
            state_in          = ST_DONE;
         end
         ST_PRIME: begin
            ctl_o.sweep_prime = 1'b1;
            state_in          = ST_RUN;
         end
         ST_RUN: begin
            ctl_o.sweep_run = 1'b1;
            if (status_i.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status_i.rsp_free) begin
               ctl_o.load_rsp = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted request not decoded next");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && status_i.sweep_last) |=> (state_ff == ST_DONE))
      else $error("sweep did not finish after last row");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      ctl_o.load_rsp |-> status_i.rsp_free)
      else $error("response loaded over a pending response");

   a_read_port: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_o.rd_cell, ctl_o.sweep_start, ctl_o.sweep_prime, ctl_o.sweep_run}))
      else $error("row memory read port claimed twice");

endmodule

// ===== design/life_grid_generation_engine_top.sv =====
// top level of the life grid generation engine
// Keeps a GRID_ROWS x GRID_COLS grid of one-bit cells (all dead after reset) and runs
// Conway's B3/S23 rule with dead cells beyond the edges. Requests are handled one at a
// time and each gives exactly one response. A toggle or read in the grid reads its row
// and, for a toggle, flips the cell before the response is loaded, a request with
// coordinates outside the grid or an unused command goes straight to the response, and a
// step first runs the sweep that reads one row and writes one new row per cycle through
// the single row memory. The response sits in an output register and waits there while
// the receiver stalls; a new request is taken in the cycle after the previous one has
// moved into it. Rows carry valid bits cleared by reset, so the grid is usable right
// after reset with no clearing pass.
module life_grid_generation_engine_top #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input logic        clock,
   input logic        reset,
   lge_req_intf.sink  req_bus,
   lge_rsp_intf.source rsp_bus
);

   lge_pkg::ctl_cmd_type    ctl;
   lge_pkg::ctl_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;
   logic                    rsp_cell_alive;
   logic                    rsp_coord_ok;

   lge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status_i  (status),
      .ctl_o     (ctl)
   );

   lge_dpath #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctl_i          (ctl),
      .status_o       (status),
      .req_cmd        (req_bus.cmd),
      .req_col        (req_bus.col),
      .req_row        (req_bus.row),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_valid),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_coord_ok   (rsp_coord_ok)
   );

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.cell_alive = rsp_cell_alive;
   assign rsp_bus.coord_ok   = rsp_coord_ok;

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the life grid generation engine
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;
   localparam int REQUEST_TARGET = 1300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = GRID_ROWS + 8;
   localparam logic [lge_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [lge_pkg::CMD_W-1:0]   cmd;
      logic [lge_pkg::COORD_W-1:0] col;
      logic [lge_pkg::COORD_W-1:0] row;
   } cell_request_type;

   typedef struct packed {
      logic cell_alive;
      logic coord_ok;
   } cell_answer_type;

   logic clock;
   logic reset;

   lge_req_intf req_bus ();
   lge_rsp_intf rsp_bus ();

   life_grid_generation_engine_top #(
      .GRID_COLS(GRID_COLS),
      .GRID_ROWS(GRID_ROWS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   cell_request_type     pending_requests[$];
   cell_answer_type      expected_answers[$];
   logic [GRID_COLS-1:0] life_rows[GRID_ROWS];
   int                   total_requests;
   int                   requests_accepted;
   int                   fail_count;
   int                   stall_cycles;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = lge_pkg::CMD_READ;
      req_bus.col = '0;
      req_bus.row = '0;
      rsp_bus.ready = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // 0: sender rarely idles, receiver mostly stalls; 1: the reverse; 2: no idling
   function automatic int idle_phase();
      if (requests_accepted * 3 < total_requests) return 0;
      if (requests_accepted * 3 < total_requests * 2) return 1;
      return 2;
   endfunction

   function automatic void advance_generation();
      logic [GRID_COLS-1:0] old_rows[GRID_ROWS];
      int neighbors;
      int rr;
      int cc;
      old_rows = life_rows;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            neighbors = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS
                      && cc >= 0 && cc < GRID_COLS)
                     neighbors += old_rows[rr][cc];
               end
            end
            life_rows[r][c] = old_rows[r][c] ? (neighbors == 2 || neighbors == 3)
                                             : (neighbors == 3);
         end
      end
   endfunction

   function automatic cell_answer_type apply_cell_request(cell_request_type item);
      cell_answer_type answer;
      answer = '0;
      case (item.cmd) inside
         lge_pkg::CMD_STEP: begin
            advance_generation();
            answer.coord_ok = 1'b1;
         end
         lge_pkg::CMD_TOGGLE, lge_pkg::CMD_READ: begin
            if (item.col < GRID_COLS && item.row < GRID_ROWS) begin
               if (item.cmd == lge_pkg::CMD_TOGGLE)
                  life_rows[item.row][item.col] = ~life_rows[item.row][item.col];
               answer.cell_alive = life_rows[item.row][item.col];
               answer.coord_ok = 1'b1;
            end
         end
         default: answer = '0;
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin : request_driver
      cell_request_type next_item;
      logic             sender_idle;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_answers.push_back(apply_cell_request({req_bus.cmd, req_bus.col,
                                                           req_bus.row}));
            requests_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            case (idle_phase())
               0: sender_idle = $urandom_range(99) < 7;
               1: sender_idle = $urandom_range(99) < 87;
               default: sender_idle = 1'b0;
            endcase
            if (pending_requests.size() != 0 && !sender_idle) begin
               next_item = pending_requests.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.cmd <= next_item.cmd;
               req_bus.col <= next_item.col;
               req_bus.row <= next_item.row;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      cell_answer_type wanted;
      logic            receiver_idle;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_answers.size() == 0) begin
               $error("response with no request outstanding: cell_alive %0b coord_ok %0b",
                      rsp_bus.cell_alive, rsp_bus.coord_ok);
               fail_count++;
            end else begin
               wanted = expected_answers.pop_front();
               if (rsp_bus.cell_alive !== wanted.cell_alive) begin
                  $error("cell_alive expected %0b actual %0b", wanted.cell_alive,
                         rsp_bus.cell_alive);
                  fail_count++;
               end
               if (rsp_bus.coord_ok !== wanted.coord_ok) begin
                  $error("coord_ok expected %0b actual %0b", wanted.coord_ok,
                         rsp_bus.coord_ok);
                  fail_count++;
               end
            end
         end
         case (idle_phase())
            0: receiver_idle = $urandom_range(99) < 87;
            1: receiver_idle = $urandom_range(99) < 7;
            default: receiver_idle = 1'b0;
         endcase
         rsp_bus.ready <= !receiver_idle;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic push_request(logic [lge_pkg::CMD_W-1:0] cmd,
                               logic [lge_pkg::COORD_W-1:0] col,
                               logic [lge_pkg::COORD_W-1:0] row);
      pending_requests.push_back({cmd, col, row});
   endtask

   function automatic logic [lge_pkg::COORD_W-1:0] pick_window_base();
      case ($urandom_range(9))
         0: return '0;
         1: return lge_pkg::COORD_W'(58);
         default: return lge_pkg::COORD_W'($urandom_range(58));
      endcase
   endfunction

   initial begin
      logic [lge_pkg::COORD_W-1:0] base_col;
      logic [lge_pkg::COORD_W-1:0] base_row;
      for (int r = 0; r < GRID_ROWS; r++) life_rows[r] = '0;
      fail_count = 0;
      stall_cycles = 0;
      requests_accepted = 0;

      // lone corner cells die on a step
      push_request(lge_pkg::CMD_TOGGLE, 0, 0);
      push_request(lge_pkg::CMD_TOGGLE, 63, 63);
      push_request(lge_pkg::CMD_TOGGLE, 0, 63);
      push_request(lge_pkg::CMD_READ, 0, 0);
      push_request(lge_pkg::CMD_READ, 63, 63);
      push_request(lge_pkg::CMD_STEP, 6'h2a, 6'h15);
      push_request(lge_pkg::CMD_READ, 0, 0);
      push_request(CMD_UNUSED, 63, 63);
      push_request(lge_pkg::CMD_TOGGLE, 0, 0);
      push_request(lge_pkg::CMD_TOGGLE, 0, 0);
      // blinker on the top edge
      push_request(lge_pkg::CMD_TOGGLE, 1, 0);
      push_request(lge_pkg::CMD_TOGGLE, 2, 0);
      push_request(lge_pkg::CMD_TOGGLE, 3, 0);
      push_request(lge_pkg::CMD_STEP, 6'h3f, 6'h3f);
      push_request(lge_pkg::CMD_READ, 2, 0);
      push_request(lge_pkg::CMD_READ, 2, 1);
      push_request(lge_pkg::CMD_READ, 1, 0);
      // block in the far corner stays put
      push_request(lge_pkg::CMD_TOGGLE, 62, 62);
      push_request(lge_pkg::CMD_TOGGLE, 63, 62);
      push_request(lge_pkg::CMD_TOGGLE, 62, 63);
      push_request(lge_pkg::CMD_TOGGLE, 63, 63);
      push_request(lge_pkg::CMD_STEP, 0, 0);
      push_request(lge_pkg::CMD_READ, 63, 63);
      push_request(CMD_UNUSED, 0, 0);
      push_request(lge_pkg::CMD_READ, 62, 62);

      while (pending_requests.size() < REQUEST_TARGET) begin
         if ($urandom_range(99) < 70) begin
            base_col = pick_window_base();
            base_row = pick_window_base();
            repeat ($urandom_range(12, 3))
               push_request(lge_pkg::CMD_TOGGLE,
                            lge_pkg::COORD_W'(base_col + $urandom_range(5)),
                            lge_pkg::COORD_W'(base_row + $urandom_range(5)));
            repeat ($urandom_range(4, 1)) begin
               push_request(lge_pkg::CMD_STEP, lge_pkg::COORD_W'($urandom),
                            lge_pkg::COORD_W'($urandom));
               repeat ($urandom_range(4, 1))
                  push_request(lge_pkg::CMD_READ,
                               lge_pkg::COORD_W'(base_col + $urandom_range(5)),
                               lge_pkg::COORD_W'(base_row + $urandom_range(5)));
            end
         end else begin
            repeat ($urandom_range(6, 1))
               push_request(lge_pkg::CMD_W'($urandom_range(3)), lge_pkg::COORD_W'($urandom),
                            lge_pkg::COORD_W'($urandom));
         end
      end
      total_requests = pending_requests.size();

      while (pending_requests.size() != 0 || req_bus.valid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_answers.size() != 0) begin
         $error("%0d responses never arrived", expected_answers.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
